// ===== hdl/mctms_pkg.sv =====
// Package for the multichannel trimmed mean sampler core.
// Field widths, history row type and the divide-by-3 constants.
// No dependencies.
`default_nettype none

package mctms_pkg;

    localparam int CH_W       = 4;
    localparam int SMP_W      = 16;
    localparam int VAL_SHIFT  = 4;
    localparam int VAL_W      = SMP_W - VAL_SHIFT;
    localparam int DEPTH      = 5;
    localparam int CHANNELS_DEF = 5;

    localparam int SUM_W      = VAL_W + $clog2(DEPTH + 1);
    localparam int TRIM_W     = VAL_W + 2;
    // floor(x / 3) == (x * 43691) >> 17 for x < 2**17
    localparam int DIV3_MUL_W = 16;
    localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 16'd43691;
    localparam int DIV3_SH    = 17;
    localparam int PROD_W     = TRIM_W + DIV3_MUL_W;

    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = CH_W + 1;
    localparam int M_TDATA_W  = 24;
    localparam int M_TUSER_W  = CH_W + 1;

    typedef logic [DEPTH-1:0][VAL_W-1:0] hist_row_t;

    typedef struct packed {
        logic              known;
        logic              push;
        logic              commit;
        logic [CH_W-1:0]   ch;
        logic [VAL_W-1:0]  value;
    } hist_req_t;

endpackage

`default_nettype wire

// ===== hdl/mctms_hist.sv =====
// Per-channel history store: one row of DEPTH shifted samples per channel.
// Gives the row after the pending push and writes it back on commit. Uses mctms_pkg.
`default_nettype none

module mctms_hist #(
    parameter int CHANNELS = mctms_pkg::CHANNELS_DEF
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  mctms_pkg::hist_req_t   req,
    output mctms_pkg::hist_row_t   row_new
);
    import mctms_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    hist_row_t            rows_reg [CHANNELS];
    hist_row_t            row_cur;
    logic [IDX_W-1:0]     idx;

    assign idx = req.ch[IDX_W-1:0];

    always_comb begin
        row_cur = '0;
        if (req.known) begin
            row_cur = rows_reg[idx];
        end
        row_new = row_cur;
        if (req.push) begin
            row_new = {row_cur[DEPTH-2:0], req.value};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                rows_reg[c] <= '0;
            end
        end else if (req.commit) begin
            rows_reg[idx] <= row_new;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mctms_stats.sv =====
// Trimmed mean of one history row: sum less max and min, divided by 3.
// Combinational; uses mctms_pkg.
`default_nettype none

module mctms_stats (
    input  mctms_pkg::hist_row_t            row,
    output logic [mctms_pkg::VAL_W-1:0]     latest,
    output logic [mctms_pkg::VAL_W-1:0]     trimmed_mean
);
    import mctms_pkg::*;

    logic [VAL_W-1:0]  mx;
    logic [VAL_W-1:0]  mn;
    logic [SUM_W-1:0]  sum;
    logic [TRIM_W-1:0] trim;
    logic [PROD_W-1:0] prod;

    always_comb begin
        mx  = row[0];
        mn  = row[0];
        sum = SUM_W'(row[0]);
        for (int i = 1; i < DEPTH; i++) begin
            if (row[i] > mx) begin
                mx = row[i];
            end
            if (row[i] < mn) begin
                mn = row[i];
            end
            sum = sum + SUM_W'(row[i]);
        end
        trim = TRIM_W'(sum - SUM_W'(mx) - SUM_W'(mn));
        prod = PROD_W'(trim) * PROD_W'(DIV3_MUL);
    end

    assign latest       = row[0];
    assign trimmed_mean = prod[DIV3_SH +: VAL_W];

endmodule

`default_nettype wire

// ===== hdl/multichannel_trimmed_mean_sampler_core.sv =====
// Top level of the multichannel trimmed mean sampler.
// Input register, history store (mctms_hist), statistics (mctms_stats), result register.
//
// Channel | Dir | tdata                                  | tuser
// s_      | in  | [15:0] sample                          | [3:0] channel, [4] valid_req
// m_      | out | [11:0] latest, [23:12] trimmed_mean    | [3:0] out_channel, [4] updated
//
// One transaction per cycle sustained while the result side is not stalled; each item
// passes the input register, then the result register.
// History read, update and writeback of a row happen in the same cycle, so items
// for the same channel may follow each other directly.
// Reset clears all history rows at once; no clearing pass.
// A stalled result holds; the input register keeps taking one more item.
`default_nettype none

module multichannel_trimmed_mean_sampler_core #(
    parameter int CHANNELS = mctms_pkg::CHANNELS_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [mctms_pkg::S_TDATA_W-1:0]   s_tdata,   // [15:0] sample
    input  wire  [mctms_pkg::S_TUSER_W-1:0]   s_tuser,   // [3:0] channel, [4] valid_req
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [mctms_pkg::M_TDATA_W-1:0]   m_tdata,   // [11:0] latest, [23:12] trimmed_mean
    output logic [mctms_pkg::M_TUSER_W-1:0]   m_tuser    // [3:0] out_channel, [4] updated
);
    import mctms_pkg::*;

    localparam logic [CH_W:0] CH_LIM = (CH_W + 1)'(CHANNELS);

    logic              in_vld_reg, in_vld_next;
    logic [CH_W-1:0]   in_ch_reg;
    logic              in_vreq_reg;
    logic [SMP_W-1:0]  in_smp_reg;

    logic              out_vld_reg, out_vld_next;
    logic [CH_W-1:0]   out_ch_reg;
    logic              out_upd_reg;
    logic [VAL_W-1:0]  out_lat_reg;
    logic [VAL_W-1:0]  out_mean_reg;

    logic              s_xfer;
    logic              adv;
    logic              known;
    hist_req_t         req;
    hist_row_t         row_new;
    logic [VAL_W-1:0]  latest;
    logic [VAL_W-1:0]  trimmed_mean;

    assign adv      = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || adv;
    assign s_xfer   = s_tvalid && s_tready;
    assign known    = {1'b0, in_ch_reg} < CH_LIM;

    always_comb begin
        req.known  = known;
        req.push   = known && in_vreq_reg;
        req.commit = adv && known && in_vreq_reg;
        req.ch     = in_ch_reg;
        req.value  = in_smp_reg[SMP_W-1:VAL_SHIFT];
    end

    mctms_hist #(
        .CHANNELS (CHANNELS)
    ) u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .row_new (row_new)
    );

    mctms_stats u_stats (
        .row          (row_new),
        .latest       (latest),
        .trimmed_mean (trimmed_mean)
    );

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_xfer) begin
            in_vld_next = 1'b1;
        end else if (adv) begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (adv) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_ch_reg   <= s_tuser[CH_W-1:0];
            in_vreq_reg <= s_tuser[CH_W];
            in_smp_reg  <= s_tdata[SMP_W-1:0];
        end
        if (adv) begin
            out_ch_reg   <= in_ch_reg;
            out_upd_reg  <= known && in_vreq_reg;
            out_lat_reg  <= known ? latest : '0;
            out_mean_reg <= known ? trimmed_mean : '0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_mean_reg, out_lat_reg};
    assign m_tuser  = {out_upd_reg, out_ch_reg};

endmodule

`default_nettype wire

// ===== hdl/mctms_checker.sv =====
// Port-level checks for multichannel_trimmed_mean_sampler_core, bound to the top level.
// Uses mctms_pkg for port widths.
`default_nettype none

module mctms_checker #(
    parameter int CHANNELS = mctms_pkg::CHANNELS_DEF
) (
    input wire                              aclk,
    input wire                              aresetn,
    input wire                              s_tvalid,
    input wire                              s_tready,
    input wire [mctms_pkg::S_TDATA_W-1:0]   s_tdata,
    input wire [mctms_pkg::S_TUSER_W-1:0]   s_tuser,
    input wire                              m_tvalid,
    input wire                              m_tready,
    input wire [mctms_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire [mctms_pkg::M_TUSER_W-1:0]   m_tuser
);
    import mctms_pkg::*;

    localparam logic [CH_W:0] CH_LIM = (CH_W + 1)'(CHANNELS);

    logic             unknown_ch;
    logic             in_seen;

    assign unknown_ch = {1'b0, m_tuser[CH_W-1:0]} >= CH_LIM;
    assign in_seen    = s_tvalid && (s_tdata != '0 || s_tuser != '0 || s_tdata == '0);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result transaction changed while stalled");

    a_unknown_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && unknown_ch |-> !m_tuser[CH_W] && m_tdata == '0)
        else $error("result for unknown channel not zero");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while result side free");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

    a_accept_then_out: assert property (@(posedge aclk) disable iff (!aresetn)
        in_seen && s_tready && !m_tvalid |-> ##[1:2] m_tvalid)
        else $error("accepted transaction did not reach result register");

endmodule

bind multichannel_trimmed_mean_sampler_core mctms_checker #(
    .CHANNELS (CHANNELS)
) u_mctms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
